### rtl/core/tpw_pkg.sv
// ============================================================================
// tpw_pkg: shared types and constants of the tuner PLL word generator
// Holds the request and write payload types, the job passed from front to
// back, and the fixed values of the band plan and the register words.
// ============================================================================
package tpw_pkg;

    // Payload of one tune request.
    typedef struct packed {
        logic [21:0] freq_khz;
        logic [25:0] sym_rate;
    } tune_t;

    // Payload of one register write.
    typedef struct packed {
        logic [1:0] reg_index;
        logic [7:0] byte_one;
        logic [7:0] byte_two;
        logic [7:0] byte_three;
        logic [1:0] data_count;
        logic       last;
    } write_t;

    // Classified request as the back end needs it.
    typedef struct packed {
        logic       pdown;
        logic       srate_low;
        logic [7:0] r0;
        logic [7:0] r1a;
        logic [7:0] r1b;
        logic [7:0] r1c;
        logic [7:0] r2a;
    } job_t;

    localparam int unsigned QUEUE_DEPTH = 2;

    // Division by 125 as a multiplication by a rounded-up reciprocal.
    // The rounding error times the largest frequency stays below 2**29,
    // so the truncated product is exact for every 22-bit input.
    localparam int unsigned    RECIP_SHIFT = 29;
    localparam int unsigned    PROD_W      = 45;
    localparam logic [22:0]    RECIP_125   = 23'd4294968;

    // Sub-register indexes.
    localparam logic [1:0] SUBREG_0 = 2'd0;
    localparam logic [1:0] SUBREG_1 = 2'd1;
    localparam logic [1:0] SUBREG_2 = 2'd2;

    // Data byte counts of each sub-register.
    localparam logic [1:0] COUNT_SUBREG_0 = 2'd1;
    localparam logic [1:0] COUNT_SUBREG_1 = 2'd3;
    localparam logic [1:0] COUNT_SUBREG_2 = 2'd2;

    // Band reference points in MHz.
    localparam logic [12:0] REF2_LO = 13'd1190;
    localparam logic [12:0] REF2_HI = 13'd1790;
    localparam logic [12:0] REF3_LO = 13'd1202;
    localparam logic [12:0] REF3_MD = 13'd1542;
    localparam logic [12:0] REF3_HI = 13'd1890;

    // VCO select codes and the fixed low bits of sub-register 0.
    localparam logic [7:0] VCO_LOW   = 8'h07;
    localparam logic [7:0] VCO_MID   = 8'h0B;
    localparam logic [7:0] VCO_HIGH  = 8'h0F;
    localparam logic [7:0] R0_FIXED  = 8'h03;

    localparam logic [12:0] DIV_SPLIT_MHZ = 13'd1525;
    localparam logic [25:0] SRATE_SPLIT   = 26'd8000000;

    // Fixed bytes.
    localparam logic [7:0] BYTE_ZERO     = 8'h00;
    localparam logic [7:0] BYTE_ONES     = 8'hFF;
    localparam logic [7:0] KICK_R0       = 8'h0F;
    localparam logic [7:0] KICK_R1_NARROW = 8'hFB;
    localparam logic [7:0] PRESCALE_R2B  = 8'h40;

endpackage

### rtl/core/tpw_front.sv
// ============================================================================
// tpw_front: request intake and classification
// Multiplies the frequency by the reciprocal of 125 in the intake register,
// then derives the band, VCO, divider, port and N/A words into a job.
// ============================================================================
module tpw_front
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    output logic           full,
    input  tpw_pkg::tune_t tune,
    output logic           job_push,
    input  logic           job_full,
    output tpw_pkg::job_t  job
);

    logic                         s1_valid_reg, s1_valid_next;
    logic                         pdown_reg, pdown_next;
    logic                         srate_low_reg, srate_low_next;
    logic [tpw_pkg::PROD_W-1:0]   prod_reg, prod_next;

    logic        advance;
    logic [15:0] nf;
    logic [12:0] zf;
    logic [12:0] near2, near3;
    logic        band2;
    logic [7:0]  vco;

    function automatic logic [12:0] gap(input logic [12:0] a, input logic [12:0] b);
        gap = (a > b) ? (a - b) : (b - a);
    endfunction

    function automatic logic [12:0] min2(input logic [12:0] a, input logic [12:0] b);
        min2 = (a < b) ? a : b;
    endfunction

    assign advance  = !s1_valid_reg || !job_full;
    assign full     = !advance;
    assign job_push = s1_valid_reg && !job_full;

    always_comb
    begin
        s1_valid_next  = s1_valid_reg;
        pdown_next     = pdown_reg;
        srate_low_next = srate_low_reg;
        prod_next      = prod_reg;
        if (advance)
        begin
            s1_valid_next  = push;
            pdown_next     = (tune.freq_khz == 22'd0);
            srate_low_next = (tune.sym_rate < tpw_pkg::SRATE_SPLIT);
            prod_next      = tpw_pkg::PROD_W'(tune.freq_khz)
                           * tpw_pkg::PROD_W'(tpw_pkg::RECIP_125);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pdown_reg     <= pdown_next;
        srate_low_reg <= srate_low_next;
        prod_reg      <= prod_next;
    end

    // nf is the frequency in units of 125 kHz; zf, in MHz, follows by a shift.
    assign nf    = prod_reg[tpw_pkg::RECIP_SHIFT +: 16];
    assign zf    = nf[15:3];
    assign near2 = min2(gap(zf, tpw_pkg::REF2_LO), gap(zf, tpw_pkg::REF2_HI));
    assign near3 = min2(min2(gap(zf, tpw_pkg::REF3_LO), gap(zf, tpw_pkg::REF3_MD)),
                        gap(zf, tpw_pkg::REF3_HI));
    assign band2 = near2 < near3;

    always_comb
    begin
        vco = tpw_pkg::BYTE_ZERO;
        if (band2)
        begin
            if ((zf >= 13'd950 && zf < 13'd1350) || (zf >= 13'd1430 && zf < 13'd1950))
                vco = tpw_pkg::VCO_LOW;
            else if ((zf >= 13'd1350 && zf < 13'd1430) || (zf >= 13'd1950 && zf < 13'd2150))
                vco = tpw_pkg::VCO_MID;
        end
        else
        begin
            if ((zf >= 13'd950 && zf < 13'd1350) || (zf >= 13'd1455 && zf < 13'd1950))
                vco = tpw_pkg::VCO_LOW;
            else if ((zf >= 13'd1350 && zf < 13'd1420) || (zf >= 13'd1950 && zf < 13'd2150))
                vco = tpw_pkg::VCO_MID;
            else if (zf >= 13'd1420 && zf < 13'd1455)
                vco = tpw_pkg::VCO_HIGH;
        end
    end

    always_comb
    begin
        job.pdown     = pdown_reg;
        job.srate_low = srate_low_reg;
        job.r0        = vco | tpw_pkg::R0_FIXED;

        job.r1a    = 8'h40;
        job.r1a[7] = (zf > tpw_pkg::DIV_SPLIT_MHZ);
        job.r2a    = 8'h0C;
        if (band2)
        begin
            job.r1a[5] = (zf <= 13'd1430);
            job.r2a[4] = 1'b1;
        end
        else
        begin
            job.r1a[5] = (zf < 13'd1630);
            job.r2a[4] = (zf < 13'd1455) || (zf >= 13'd1630);
        end
        // Port bits: wide symbol rates set both bits, narrow ones only the upper.
        job.r1a[3]   = 1'b1;
        job.r1a[2]   = !srate_low_reg;
        // N = nf/32 and A = (2*nf) mod 64 fall out as bit fields of nf.
        job.r1a[1:0] = nf[15:14];
        job.r1b      = nf[13:6];
        job.r1c      = {nf[5], 1'b0, nf[4:0], 1'b0};
    end

endmodule

### rtl/core/tpw_queue.sv
// ============================================================================
// tpw_queue: job queue between front and back
// A small first-in first-out store of classified requests.
// ============================================================================
module tpw_queue
#(
    parameter int unsigned DEPTH = tpw_pkg::QUEUE_DEPTH
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_en,
    input  tpw_pkg::job_t wr_data,
    output logic          full,
    input  logic          rd_en,
    output logic          rd_valid,
    output tpw_pkg::job_t rd_data
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    tpw_pkg::job_t    mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr, do_rd;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = mem[rd_ptr_reg];
    assign do_wr    = wr_en && !full;
    assign do_rd    = rd_en && rd_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_rd)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_wr && !do_rd)
            count_next = count_reg + 1'b1;
        else if (do_rd && !do_wr)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem[wr_ptr_reg] <= wr_data;
    end

endmodule

### rtl/core/tpw_back.sv
// ============================================================================
// tpw_back: register-write sequencer
// Walks a job's writes into the output register, one per cycle unless stalled.
// ============================================================================
module tpw_back
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            job_valid,
    input  tpw_pkg::job_t   job,
    output logic            job_pop,
    output logic            empty,
    input  logic            pop,
    output tpw_pkg::write_t result
);

    typedef enum logic [2:0] {
        STEP_KICK0,
        STEP_KICK1,
        STEP_KICK2,
        STEP_SET2,
        STEP_SET0,
        STEP_SET1
    } step_t;

    step_t           step_reg, step_next;
    logic            out_valid_reg, out_valid_next;
    tpw_pkg::write_t result_reg, result_next;
    tpw_pkg::write_t wr;
    logic            load;
    logic            last_step;

    assign load      = !out_valid_reg || pop;
    assign last_step = job.pdown ? (step_reg == STEP_KICK2) : (step_reg == STEP_SET1);
    assign empty     = !out_valid_reg;
    assign result    = result_reg;

    // Write contents of the current step.
    always_comb
    begin
        wr            = '0;
        wr.last       = last_step;
        case (step_reg)
            STEP_KICK0:
            begin
                wr.reg_index  = tpw_pkg::SUBREG_0;
                wr.data_count = tpw_pkg::COUNT_SUBREG_0;
                wr.byte_one   = job.pdown ? tpw_pkg::BYTE_ZERO : tpw_pkg::KICK_R0;
            end
            STEP_KICK1:
            begin
                wr.reg_index  = tpw_pkg::SUBREG_1;
                wr.data_count = tpw_pkg::COUNT_SUBREG_1;
                wr.byte_one   = (!job.pdown && job.srate_low) ? tpw_pkg::KICK_R1_NARROW
                                                              : tpw_pkg::BYTE_ONES;
                wr.byte_two   = tpw_pkg::BYTE_ONES;
                wr.byte_three = job.pdown ? tpw_pkg::BYTE_ONES : tpw_pkg::BYTE_ZERO;
            end
            STEP_KICK2:
            begin
                wr.reg_index  = tpw_pkg::SUBREG_2;
                wr.data_count = tpw_pkg::COUNT_SUBREG_2;
                wr.byte_one   = tpw_pkg::BYTE_ONES;
                wr.byte_two   = tpw_pkg::BYTE_ONES;
            end
            STEP_SET2:
            begin
                wr.reg_index  = tpw_pkg::SUBREG_2;
                wr.data_count = tpw_pkg::COUNT_SUBREG_2;
                wr.byte_one   = job.r2a;
                wr.byte_two   = tpw_pkg::PRESCALE_R2B;
            end
            STEP_SET0:
            begin
                wr.reg_index  = tpw_pkg::SUBREG_0;
                wr.data_count = tpw_pkg::COUNT_SUBREG_0;
                wr.byte_one   = job.r0;
            end
            STEP_SET1:
            begin
                wr.reg_index  = tpw_pkg::SUBREG_1;
                wr.data_count = tpw_pkg::COUNT_SUBREG_1;
                wr.byte_one   = job.r1a;
                wr.byte_two   = job.r1b;
                wr.byte_three = job.r1c;
            end
            default:
            begin
                wr.reg_index  = tpw_pkg::SUBREG_0;
                wr.data_count = tpw_pkg::COUNT_SUBREG_0;
            end
        endcase
    end

    always_comb
    begin
        step_next      = step_reg;
        out_valid_next = out_valid_reg && !pop;
        result_next    = result_reg;
        job_pop        = 1'b0;
        if (load && job_valid)
        begin
            out_valid_next = 1'b1;
            result_next    = wr;
            if (last_step)
            begin
                job_pop   = 1'b1;
                step_next = STEP_KICK0;
            end
            else
            begin
                case (step_reg)
                    STEP_KICK0: step_next = STEP_KICK1;
                    STEP_KICK1: step_next = STEP_KICK2;
                    STEP_KICK2: step_next = STEP_SET2;
                    STEP_SET2:  step_next = STEP_SET0;
                    STEP_SET0:  step_next = STEP_SET1;
                    default:    step_next = STEP_KICK0;
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= STEP_KICK0;
            out_valid_reg <= 1'b0;
            result_reg    <= '0;
        end
        else
        begin
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
            result_reg    <= result_next;
        end
    end

endmodule

### rtl/core/tuner_pll_word_generator.sv
// ============================================================================
// tuner_pll_word_generator: tuner PLL register-write sequence generator
// Turns a tune request into the register writes that program the PLL.
// ============================================================================
// Each tune request yields six register writes, or three when the frequency
// is zero (power-down), delivered one per clock while the consumer pops; the
// write sequencer emits a single write per cycle while its output register
// is free or popped and a job waits. A request is first held in the front
// end's intake register, with the reciprocal product that replaces the
// division by 125, and classification follows in the same cycle; its job
// then enters a two-entry queue, and from the queue the sequencer registers
// its first write into the output register once that register is free. The
// front end keeps accepting requests while the sequencer and the output
// register are busy, until the queue fills; full then holds off further
// pushes. Write payloads carry unused data bytes as zero.
// ============================================================================
module tuner_pll_word_generator
#(
    parameter int unsigned QUEUE_DEPTH = tpw_pkg::QUEUE_DEPTH
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    output logic            full,
    input  tpw_pkg::tune_t  tune,
    output logic            empty,
    input  logic            pop,
    output tpw_pkg::write_t result
);

    // Front-to-queue and queue-to-back connections.
    logic          job_push;
    logic          job_full;
    tpw_pkg::job_t job_in;
    logic          job_valid;
    logic          job_pop;
    tpw_pkg::job_t job_out;

    // The front end registers the request together with its reciprocal
    // product, then classifies it into the precomputed register words.
    tpw_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .tune     (tune),
        .job_push (job_push),
        .job_full (job_full),
        .job      (job_in)
    );

    // The queue decouples classification from write sequencing.
    tpw_queue
    #(
        .DEPTH (QUEUE_DEPTH)
    )
    u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (job_push),
        .wr_data  (job_in),
        .full     (job_full),
        .rd_en    (job_pop),
        .rd_valid (job_valid),
        .rd_data  (job_out)
    );

    // The sequencer releases the job once its last write is registered.
    tpw_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (job_valid),
        .job       (job_out),
        .job_pop   (job_pop),
        .empty     (empty),
        .pop       (pop),
        .result    (result)
    );

endmodule

### rtl/core/tpw_checker.sv
// ============================================================================
// tpw_checker: port-level checks of the tuner PLL word generator
// Watches the write queue side and checks write shape and ordering.
// ============================================================================
module tpw_checker
(
    input logic            clk,
    input logic            rst_n,
    input logic            empty,
    input logic            pop,
    input tpw_pkg::write_t result
);

    // A waiting write holds until it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(result)))
    else $error("waiting write changed before it was popped");

    // Each sub-register is written with its own byte count.
    assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> ((result.reg_index == tpw_pkg::SUBREG_0
                         && result.data_count == tpw_pkg::COUNT_SUBREG_0)
                 || (result.reg_index == tpw_pkg::SUBREG_1
                         && result.data_count == tpw_pkg::COUNT_SUBREG_1)
                 || (result.reg_index == tpw_pkg::SUBREG_2
                         && result.data_count == tpw_pkg::COUNT_SUBREG_2)))
    else $error("write has a bad register index or byte count");

    // Bytes beyond the count are zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.data_count != tpw_pkg::COUNT_SUBREG_1)
            |-> (result.byte_three == tpw_pkg::BYTE_ZERO
                 && (result.data_count != tpw_pkg::COUNT_SUBREG_0
                     || result.byte_two == tpw_pkg::BYTE_ZERO)))
    else $error("unused data byte is not zero");

    // Within a sequence, a write to sub-register 0 is always followed by one
    // to sub-register 1.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && pop && !result.last && result.reg_index == tpw_pkg::SUBREG_0)
            |=> (empty || result.reg_index == tpw_pkg::SUBREG_1))
    else $error("sub-register 0 write not followed by sub-register 1");

endmodule

bind tuner_pll_word_generator tpw_checker u_tpw_checker
(
    .clk    (clk),
    .rst_n  (rst_n),
    .empty  (empty),
    .pop    (pop),
    .result (result)
);

### tb/tb_top.sv
// ============================================================================
// tb_top: self-checking testbench of the tuner PLL word generator
// Sends tune requests through the push/full side, predicts the register
// writes that each one must produce, and checks every write popped from the
// empty/pop side, in order and field by field, under random stalls on both
// sides.
// ============================================================================

// Keeps the register writes still owed by the block, oldest first, and
// checks each popped write against the head of that list.
class write_sequence_checker;

    tpw_pkg::write_t owed_writes[$];
    int unsigned     bad_count;

    function new();
        bad_count = 0;
    endfunction

    function int unsigned pending();
        return owed_writes.size();
    endfunction

    static function int unsigned spread(int unsigned a, int unsigned b);
        return (a > b) ? a - b : b - a;
    endfunction

    static function int unsigned lesser(int unsigned a, int unsigned b);
        return (a < b) ? a : b;
    endfunction

    // Unused data bytes are carried as zero, so they are zeroed here too.
    function void owe(logic [1:0] idx, logic [7:0] b1, logic [7:0] b2,
                      logic [7:0] b3, logic [1:0] cnt, logic is_last);
        tpw_pkg::write_t w;
        w.reg_index  = idx;
        w.byte_one   = b1;
        w.byte_two   = (cnt >= 2) ? b2 : 8'h00;
        w.byte_three = (cnt >= 3) ? b3 : 8'h00;
        w.data_count = cnt;
        w.last       = is_last;
        owed_writes.push_back(w);
    endfunction

    // Works out the write sequence of one accepted tune request.
    function void note_tune(tpw_pkg::tune_t t);
        int unsigned f, sr, mhz, d_two, d_three, nf, n, a;
        logic [7:0]  r0, r1a, r1b, r1c, r2a;
        bit          two_ref_band;
        f  = t.freq_khz;
        sr = t.sym_rate;
        if (f == 0)
        begin
            owe(tpw_pkg::SUBREG_0, 8'h00, 8'h00, 8'h00, tpw_pkg::COUNT_SUBREG_0, 1'b0);
            owe(tpw_pkg::SUBREG_1, 8'hFF, 8'hFF, 8'hFF, tpw_pkg::COUNT_SUBREG_1, 1'b0);
            owe(tpw_pkg::SUBREG_2, 8'hFF, 8'hFF, 8'h00, tpw_pkg::COUNT_SUBREG_2, 1'b1);
            return;
        end
        mhz     = f / 1000;
        d_two   = lesser(spread(mhz, 1190), spread(mhz, 1790));
        d_three = lesser(lesser(spread(mhz, 1202), spread(mhz, 1542)),
                         spread(mhz, 1890));
        two_ref_band = d_two < d_three;

        r0 = 8'h00;
        if (two_ref_band)
        begin
            if ((mhz >= 950 && mhz < 1350) || (mhz >= 1430 && mhz < 1950))
                r0 = tpw_pkg::VCO_LOW;
            else if ((mhz >= 1350 && mhz < 1430) || (mhz >= 1950 && mhz < 2150))
                r0 = tpw_pkg::VCO_MID;
        end
        else
        begin
            if ((mhz >= 950 && mhz < 1350) || (mhz >= 1455 && mhz < 1950))
                r0 = tpw_pkg::VCO_LOW;
            else if ((mhz >= 1350 && mhz < 1420) || (mhz >= 1950 && mhz < 2150))
                r0 = tpw_pkg::VCO_MID;
            else if (mhz >= 1420 && mhz < 1455)
                r0 = tpw_pkg::VCO_HIGH;
        end
        r0 = r0 | tpw_pkg::R0_FIXED;

        r1a = 8'h00;
        r2a = 8'h00;
        if (mhz > 1525)
            r1a = r1a | 8'h80;
        if (two_ref_band)
        begin
            if (mhz <= 1430)
                r1a = r1a | 8'h20;
            r2a = r2a | 8'h10;
        end
        else if (mhz < 1455)
        begin
            r1a = r1a | 8'h20;
            r2a = r2a | 8'h10;
        end
        else if (mhz < 1630)
            r1a = r1a | 8'h20;
        else
            r2a = r2a | 8'h10;
        r1a = r1a | ((sr >= 8000000) ? 8'h0C : 8'h08);
        r2a = r2a | 8'h0C;

        nf  = f / 125;
        a   = (2 * nf) & 63;
        n   = nf / 32;
        r1a = r1a | 8'(n >> 9 & 3) | 8'h40;
        r1b = 8'(n >> 1);
        r1c = 8'(((n & 1) << 7) | a);

        owe(tpw_pkg::SUBREG_0, tpw_pkg::KICK_R0, 8'h00, 8'h00,
            tpw_pkg::COUNT_SUBREG_0, 1'b0);
        owe(tpw_pkg::SUBREG_1,
            (sr < 8000000) ? tpw_pkg::KICK_R1_NARROW : tpw_pkg::BYTE_ONES,
            tpw_pkg::BYTE_ONES, tpw_pkg::BYTE_ZERO, tpw_pkg::COUNT_SUBREG_1, 1'b0);
        owe(tpw_pkg::SUBREG_2, tpw_pkg::BYTE_ONES, tpw_pkg::BYTE_ONES, 8'h00,
            tpw_pkg::COUNT_SUBREG_2, 1'b0);
        owe(tpw_pkg::SUBREG_2, r2a, tpw_pkg::PRESCALE_R2B, 8'h00,
            tpw_pkg::COUNT_SUBREG_2, 1'b0);
        owe(tpw_pkg::SUBREG_0, r0, 8'h00, 8'h00, tpw_pkg::COUNT_SUBREG_0, 1'b0);
        owe(tpw_pkg::SUBREG_1, r1a, r1b, r1c, tpw_pkg::COUNT_SUBREG_1, 1'b1);
    endfunction

    function void check_write(tpw_pkg::write_t got);
        tpw_pkg::write_t want;
        if (owed_writes.size() == 0)
        begin
            bad_count++;
            if (bad_count <= 10)
                $display("unexpected write: reg %0d bytes %h %h %h count %0d last %0d",
                         got.reg_index, got.byte_one, got.byte_two, got.byte_three,
                         got.data_count, got.last);
            return;
        end
        want = owed_writes.pop_front();
        if (got.reg_index !== want.reg_index || got.byte_one !== want.byte_one ||
            got.byte_two !== want.byte_two || got.byte_three !== want.byte_three ||
            got.data_count !== want.data_count || got.last !== want.last)
        begin
            bad_count++;
            if (bad_count <= 10)
            begin
                $display("write mismatch: expected reg %0d bytes %h %h %h count %0d last %0d",
                         want.reg_index, want.byte_one, want.byte_two, want.byte_three,
                         want.data_count, want.last);
                $display("                got      reg %0d bytes %h %h %h count %0d last %0d",
                         got.reg_index, got.byte_one, got.byte_two, got.byte_three,
                         got.data_count, got.last);
            end
        end
    endfunction

endclass

module tb_top;

    logic            clk;
    logic            rst_n;
    logic            push;
    logic            full;
    tpw_pkg::tune_t  tune;
    logic            empty;
    logic            pop;
    tpw_pkg::write_t result;

    // When set, neither side idles any more; used for the closing stretch.
    bit steady;

    write_sequence_checker book;

    // Directed requests: power-down with both symbol-rate extremes, the
    // frequency extremes, and the edges of every VCO range, divider split and
    // port split, on both sides of the band choice.
    int unsigned edge_freq [23] = '{
        0, 0, 4194303, 1, 949999, 950000, 1190000, 1349999, 1350000,
        1419999, 1420000, 1430000, 1454999, 1455000, 1525999, 1526000,
        1629999, 1630000, 1700000, 1949999, 1950000, 2149999, 2150000
    };
    int unsigned edge_srate [23] = '{
        0, 67108863, 67108863, 0, 7999999, 8000000, 27500000, 7999999,
        8000000, 7999999, 8000000, 22000000, 1000000, 8000000, 7999999,
        8000000, 30000000, 2000000, 7999999, 8000000, 45000000, 7999999,
        8000000
    };

    tuner_pll_word_generator u_top
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .tune   (tune),
        .empty  (empty),
        .pop    (pop),
        .result (result)
    );

    initial
    begin
        clk = 1'b0;
        forever
            #6 clk = ~clk;
    end

    // Hard stop well beyond the slowest correct run.
    initial
    begin
        #2000000;
        $display("tb: failure");
        $finish;
    end

    // Presents one request and holds it until the block takes it. Push is
    // left high afterwards so that back-to-back requests keep it asserted;
    // an optional idle gap of random length comes first.
    task automatic send_tune(input tpw_pkg::tune_t t);
        if (!steady && $urandom_range(0, 2) == 0)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 4))
                @(posedge clk);
        end
        push <= 1'b1;
        tune <= t;
        @(posedge clk);
        while (full !== 1'b0)
            @(posedge clk);
        book.note_tune(t);
    endtask

    // Holds the sender off until every owed write has been popped.
    task automatic drain_writes();
        push <= 1'b0;
        while (book.pending() != 0)
            @(posedge clk);
    endtask

    // Random request: mostly frequencies in the tuning band, some over the
    // whole 22-bit range and some power-downs; symbol rates are either full
    // range or close to the port split.
    function automatic tpw_pkg::tune_t random_tune();
        tpw_pkg::tune_t t;
        int unsigned    pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            t.freq_khz = '0;
        else if (pick <= 2)
            t.freq_khz = 22'($urandom);
        else
            t.freq_khz = 22'($urandom_range(900000, 2200000));
        if ($urandom_range(0, 1) == 0)
            t.sym_rate = 26'($urandom);
        else
            t.sym_rate = 26'($urandom_range(7990000, 8010000));
        return t;
    endfunction

    // Write side: a popped write is taken at an edge where pop is high and
    // empty is low. Pop drops in random bursts.
    initial
    begin
        int hold;
        hold = 0;
        pop <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && pop && empty === 1'b0)
                book.check_write(result);
            if (hold > 0)
            begin
                hold--;
                pop <= 1'b0;
            end
            else if (!steady && rst_n && $urandom_range(0, 5) == 0)
            begin
                hold = $urandom_range(0, 3);
                pop <= 1'b0;
            end
            else
                pop <= 1'b1;
        end
    end

    initial
    begin
        tpw_pkg::tune_t t;
        book   = new();
        steady = 1'b0;
        rst_n  = 1'b0;
        push   = 1'b0;
        tune   = '0;
        repeat (7)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (edge_freq[k])
        begin
            t.freq_khz = 22'(edge_freq[k]);
            t.sym_rate = 26'(edge_srate[k]);
            send_tune(t);
        end

        // Let the block run completely dry once before the random part.
        drain_writes();

        for (int k = 0; k < 137; k++)
        begin
            // The closing stretch runs with both sides at full speed.
            if (k == 110)
                steady = 1'b1;
            send_tune(random_tune());
        end

        drain_writes();
        repeat (20)
            @(posedge clk);
        if (book.bad_count == 0 && book.pending() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
